// ===== rtl/sfd_pkg.sv =====
// Package for the sensor frame deframer: frame constants, register indexes
// and the structures passed between the window, evaluation and scaling stages.
// No dependencies.
package sfd_pkg;

   localparam int FRAME_BYTES_DEF = 40;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] HEAD_BYTE = 8'hFE;
   localparam logic [7:0] TAIL_BYTE = 8'hFD;

   localparam logic [31:0] SUPPLY_COEF_DEF  = 32'd46339;
   localparam logic [31:0] CHANNEL_COEF_DEF = 32'd390860;
   localparam logic [15:0] TEMP_INVALID     = 16'h8000;

   localparam int EQUIPMENT_POS    = 18;
   localparam int TEMP_POS         = 19;
   localparam int SUPPLY_POS       = 21;
   localparam int BIAS_A_POS       = 23;
   localparam int BIAS_B_POS       = 25;
   localparam int COUNT_FIRST_POS  = 3;
   localparam int COUNT_SECOND_POS = 7;
   localparam int COUNT_THIRD_POS  = 11;
   localparam int COUNT_FOURTH_POS = 15;

   localparam int MASK_SUPPLY = 0;
   localparam int MASK_BIAS_A = 1;
   localparam int MASK_BIAS_B = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATCH_EQUIPMENT = 3'd0,
      CSR_MATCH_MASK      = 3'd1,
      CSR_SUPPLY_COEF     = 3'd2,
      CSR_CHANNEL_A_COEF  = 3'd3,
      CSR_CHANNEL_B_COEF  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  match_equipment;
      logic [2:0]  match_enable_mask;
      logic [31:0] supply_coef;
      logic [31:0] channel_a_coef;
      logic [31:0] channel_b_coef;
   } csr_type;

   typedef struct packed {
      logic [7:0]  equipment;
      logic [15:0] temperature;
      logic [15:0] supply_word;
      logic [15:0] bias_a_word;
      logic [15:0] bias_b_word;
      logic [31:0] supply_coef;
      logic [31:0] bias_a_coef;
      logic [31:0] bias_b_coef;
      logic [23:0] count_first;
      logic [23:0] count_second;
      logic [23:0] count_third;
      logic [23:0] count_fourth;
   } field_type;

   typedef struct packed {
      logic [7:0]         equipment;
      logic signed [15:0] temperature_q7;
      logic [47:0]        supply_volts_q24;
      logic [47:0]        bias_a_volts_q24;
      logic [47:0]        bias_b_volts_q24;
      logic [23:0]        count_first;
      logic [23:0]        count_second;
      logic [23:0]        count_third;
      logic [23:0]        count_fourth;
   } result_type;

endpackage

// ===== rtl/sfd_cell.sv =====
// One byte cell of the deframer window.
// Holds a byte and takes its neighbour's byte on each shift; no dependencies.
module sfd_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  logic [7:0] left_data,
   output logic [7:0] cell_data
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = shift_en ? left_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign cell_data = data_ff;

endmodule

// ===== rtl/sfd_eval.sv =====
// Frame evaluation for the deframer: header and tail detection, tail spacing,
// overlap skip and capture of the frame fields. Depends on sfd_pkg.
module sfd_eval import sfd_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      step_fire,
   input  logic [7:0] window [FRAME_BYTES],
   input  csr_type   csr,
   input  logic      s1_pop,
   output logic      s1_valid,
   output field_type s1_fields
);

   localparam int CNT_W = $clog2(FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_BYTES - 1);

   logic [CNT_W-1:0] skip_ff, skip_in;
   logic [CNT_W-1:0] gap_ff, gap_in;
   logic             s1_valid_ff, s1_valid_in;
   field_type        fields_ff, fields_in;
   logic             header, tail, hit, match;

   always_comb begin
      header = (window[0] == SYNC_BYTE) && (window[1] == HEAD_BYTE);
      tail   = (window[FRAME_BYTES-2] == SYNC_BYTE) && (window[FRAME_BYTES-1] == TAIL_BYTE);
      hit    = step_fire && (skip_ff == '0) && header && tail && (gap_ff == CNT_MAX);

      gap_in  = gap_ff;
      skip_in = skip_ff;
      if (step_fire) begin
         if (tail) begin
            gap_in = CNT_W'(1);
         end else if (gap_ff != CNT_MAX) begin
            gap_in = gap_ff + CNT_W'(1);
         end
         if (skip_ff != '0) begin
            skip_in = skip_ff - CNT_W'(1);
         end else if (hit) begin
            skip_in = CNT_MAX;
         end
      end

      if (hit) begin
         s1_valid_in = 1'b1;
      end else if (s1_pop) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      match = (window[EQUIPMENT_POS] == csr.match_equipment);
      fields_in.equipment   = window[EQUIPMENT_POS];
      fields_in.temperature = {window[TEMP_POS], window[TEMP_POS+1]};
      if (fields_in.temperature == TEMP_INVALID) begin
         fields_in.temperature = '0;
      end
      fields_in.supply_word  = {window[SUPPLY_POS], window[SUPPLY_POS+1]};
      fields_in.bias_a_word  = {window[BIAS_A_POS], window[BIAS_A_POS+1]};
      fields_in.bias_b_word  = {window[BIAS_B_POS], window[BIAS_B_POS+1]};
      fields_in.supply_coef  = (match && csr.match_enable_mask[MASK_SUPPLY])
                               ? csr.supply_coef : SUPPLY_COEF_DEF;
      fields_in.bias_a_coef  = (match && csr.match_enable_mask[MASK_BIAS_A])
                               ? csr.channel_a_coef : CHANNEL_COEF_DEF;
      fields_in.bias_b_coef  = (match && csr.match_enable_mask[MASK_BIAS_B])
                               ? csr.channel_b_coef : CHANNEL_COEF_DEF;
      fields_in.count_first  = {window[COUNT_FIRST_POS], window[COUNT_FIRST_POS+1],
                                window[COUNT_FIRST_POS+2]};
      fields_in.count_second = {window[COUNT_SECOND_POS], window[COUNT_SECOND_POS+1],
                                window[COUNT_SECOND_POS+2]};
      fields_in.count_third  = {window[COUNT_THIRD_POS], window[COUNT_THIRD_POS+1],
                                window[COUNT_THIRD_POS+2]};
      fields_in.count_fourth = {window[COUNT_FOURTH_POS], window[COUNT_FOURTH_POS+1],
                                window[COUNT_FOURTH_POS+2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff     <= '0;
         gap_ff      <= CNT_MAX;
         s1_valid_ff <= 1'b0;
      end else begin
         skip_ff     <= skip_in;
         gap_ff      <= gap_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         fields_ff <= fields_in;
      end
   end

   assign s1_valid  = s1_valid_ff;
   assign s1_fields = fields_ff;

endmodule

// ===== rtl/sfd_scale.sv =====
// Scaling stage of the deframer: three 16 by 32 bit products into the result
// register, which holds a result until its transfer. Depends on sfd_pkg.
module sfd_scale import sfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s1_pop,
   input  field_type  s1_fields,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type result
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   always_comb begin
      if (s1_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      result_in.equipment        = s1_fields.equipment;
      result_in.temperature_q7   = signed'(s1_fields.temperature);
      result_in.supply_volts_q24 = 48'(s1_fields.supply_word) * 48'(s1_fields.supply_coef);
      result_in.bias_a_volts_q24 = 48'(s1_fields.bias_a_word) * 48'(s1_fields.bias_a_coef);
      result_in.bias_b_volts_q24 = 48'(s1_fields.bias_b_word) * 48'(s1_fields.bias_b_coef);
      result_in.count_first      = s1_fields.count_first;
      result_in.count_second     = s1_fields.count_second;
      result_in.count_third      = s1_fields.count_third;
      result_in.count_fourth     = s1_fields.count_fourth;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_pop) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

// ===== rtl/sensor_frame_deframer.sv =====
// Top level of the sensor frame deframer: a row of byte cells, frame evaluation,
// scaling and the configuration registers. Depends on sfd_pkg, sfd_cell,
// sfd_eval and sfd_scale.
//
//   Channel  Direction  Transfer                 Moves
//   req_     in         req_valid & req_ready    one stream byte
//   rsp_     out        rsp_valid & rsp_ready    one decoded frame
//   csr_     in         csr_write_enable         one register write
//
// One byte is taken per cycle while req_ready is high and is evaluated once shifted
// into the window. The evaluation stage, one capture stage and the result register
// each hold one item, in that order towards rsp_; req_ready falls only while
// evaluation is pending, both later stages are full and rsp_ready is low. Reset
// clears the window to zeros and the registers to defaults.
module sensor_frame_deframer import sfd_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_stream_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_equipment,
   output logic signed [15:0]     rsp_temperature_q7,
   output logic [47:0]            rsp_supply_volts_q24,
   output logic [47:0]            rsp_bias_a_volts_q24,
   output logic [47:0]            rsp_bias_b_volts_q24,
   output logic [23:0]            rsp_count_first,
   output logic [23:0]            rsp_count_second,
   output logic [23:0]            rsp_count_third,
   output logic [23:0]            rsp_count_fourth,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic       req_accept;
   logic       step_ff, step_in;
   logic       step_fire;
   logic       out_free, s1_free, s1_pop, s1_valid;
   logic [7:0] window [FRAME_BYTES];
   csr_type    csr_ff, csr_in;
   field_type  s1_fields;
   result_type result;

   assign out_free   = !rsp_valid || rsp_ready;
   assign s1_pop     = s1_valid && out_free;
   assign s1_free    = !s1_valid || out_free;
   assign step_fire  = step_ff && s1_free;
   assign req_ready  = !step_ff || s1_free;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      if (req_accept) begin
         step_in = 1'b1;
      end else if (step_fire) begin
         step_in = 1'b0;
      end else begin
         step_in = step_ff;
      end
   end

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MATCH_EQUIPMENT: csr_in.match_equipment   = csr_wdata[7:0];
            CSR_MATCH_MASK:      csr_in.match_enable_mask = csr_wdata[2:0];
            CSR_SUPPLY_COEF:     csr_in.supply_coef       = csr_wdata;
            CSR_CHANNEL_A_COEF:  csr_in.channel_a_coef    = csr_wdata;
            CSR_CHANNEL_B_COEF:  csr_in.channel_b_coef    = csr_wdata;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff                  <= 1'b0;
         csr_ff.match_equipment   <= '0;
         csr_ff.match_enable_mask <= '0;
         csr_ff.supply_coef       <= SUPPLY_COEF_DEF;
         csr_ff.channel_a_coef    <= CHANNEL_COEF_DEF;
         csr_ff.channel_b_coef    <= CHANNEL_COEF_DEF;
      end else begin
         step_ff <= step_in;
         csr_ff  <= csr_in;
      end
   end

   for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
      if (i == FRAME_BYTES - 1) begin : g_last
         sfd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (req_accept),
            .left_data (req_stream_byte),
            .cell_data (window[i])
         );
      end else begin : g_mid
         sfd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (req_accept),
            .left_data (window[i+1]),
            .cell_data (window[i])
         );
      end
   end

   sfd_eval #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .window    (window),
      .csr       (csr_ff),
      .s1_pop    (s1_pop),
      .s1_valid  (s1_valid),
      .s1_fields (s1_fields)
   );

   sfd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .s1_pop    (s1_pop),
      .s1_fields (s1_fields),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .result    (result)
   );

   assign rsp_equipment        = result.equipment;
   assign rsp_temperature_q7   = result.temperature_q7;
   assign rsp_supply_volts_q24 = result.supply_volts_q24;
   assign rsp_bias_a_volts_q24 = result.bias_a_volts_q24;
   assign rsp_bias_b_volts_q24 = result.bias_b_volts_q24;
   assign rsp_count_first      = result.count_first;
   assign rsp_count_second     = result.count_second;
   assign rsp_count_third      = result.count_third;
   assign rsp_count_fourth     = result.count_fourth;

endmodule

// ===== rtl/sfd_checker.sv =====
// Port checker for the sensor frame deframer and its bind to the top level.
// Depends on the top level's port list only.
module sfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_equipment,
   input logic signed [15:0] rsp_temperature_q7,
   input logic [47:0]        rsp_supply_volts_q24,
   input logic [47:0]        rsp_bias_a_volts_q24,
   input logic [47:0]        rsp_bias_b_volts_q24,
   input logic [23:0]        rsp_count_first,
   input logic [23:0]        rsp_count_second,
   input logic [23:0]        rsp_count_third,
   input logic [23:0]        rsp_count_fourth
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result withdrawn before its transfer.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_equipment, rsp_temperature_q7,
         rsp_supply_volts_q24, rsp_bias_a_volts_q24, rsp_bias_b_volts_q24,
         rsp_count_first, rsp_count_second, rsp_count_third, rsp_count_fourth}))
      else $error("Result changed while stalled.");

   a_no_invalid_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature_q7 != 16'sh8000)
      else $error("Invalid temperature code reached the output.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result offered straight after reset.");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (.*);

// ===== tb/sensor_frame_deframer_test.sv =====
// Self-checking testbench for sensor_frame_deframer: directed frames from a table, then
// random byte streams of good, broken and noisy frames under several register settings.
// Depends on sfd_pkg and the sensor_frame_deframer RTL.
module sensor_frame_deframer_test import sfd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BYTES       = FRAME_BYTES_DEF;
   localparam int SETTLE_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES  = 400;
   localparam int PHASES            = 5;
   localparam int PHASE_BYTES       = 140;
   localparam int PHASE_FRAMES      = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef enum {
      ROW_FRAME, ROW_EARLY_TAIL, ROW_LATE_TAIL, ROW_RESTART, ROW_NESTED, ROW_NOISE
   } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [7:0]        equipment;
      logic [15:0]       temperature;
      logic [15:0]       supply_word;
      logic [15:0]       bias_a_word;
      logic [15:0]       bias_b_word;
      logic [0:3][23:0]  counts;
      bit                typed;
      result_type        typed_frame;
   } frame_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_stream_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_equipment;
   logic signed [15:0]     rsp_temperature_q7;
   logic [47:0]            rsp_supply_volts_q24;
   logic [47:0]            rsp_bias_a_volts_q24;
   logic [47:0]            rsp_bias_b_volts_q24;
   logic [23:0]            rsp_count_first;
   logic [23:0]            rsp_count_second;
   logic [23:0]            rsp_count_third;
   logic [23:0]            rsp_count_fourth;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [7:0]   line_window [FRAME_BYTES];
   logic [5:0]   skip_left;
   csr_type      csr_model;
   result_type   frames_due [$];
   result_type   due_frame;
   result_type   table_frame;
   bit           table_pending;
   bit           hold_wanted;
   int           mismatches;
   int           bytes_sent;
   int           frames_predicted;
   int           burst_left;

   frame_row_type directed_rows [12] = '{
      '{ROW_FRAME, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, {4{24'h000000}}, 1'b1,
        '{8'h00, 16'sd0, 48'd0, 48'd0, 48'd0, 24'h000000, 24'h000000, 24'h000000,
          24'h000000}},
      '{ROW_FRAME, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, {4{24'hFFFFFF}}, 1'b1,
        '{8'hFF, -16'sd1, 48'd3036826365, 48'd25615010100, 48'd25615010100, 24'hFFFFFF,
          24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}},
      '{ROW_FRAME, 8'h12, 16'h8000, 16'h0001, 16'h0001, 16'h0001, {4{24'h000001}}, 1'b1,
        '{8'h12, 16'sd0, 48'd46339, 48'd390860, 48'd390860, 24'h000001, 24'h000001,
          24'h000001, 24'h000001}},
      '{ROW_FRAME, 8'h01, 16'h7FFF, 16'h8000, 16'h00FF, 16'hFF00,
        {24'h123456, 24'h800000, 24'h7FFFFF, 24'h000100}, 1'b0, '0},
      '{ROW_FRAME, 8'h80, 16'h8001, 16'h1234, 16'hABCD, 16'h5A5A,
        {24'hFEDCBA, 24'h00FF00, 24'h0000FF, 24'hFF0000}, 1'b0, '0},
      '{ROW_EARLY_TAIL, 8'h33, 16'h0100, 16'h2222, 16'h3333, 16'h4444, {4{24'h010203}},
        1'b0, '0},
      '{ROW_FRAME, 8'hFE, 16'hFFFE, 16'h7FFF, 16'h0002, 16'hC000,
        {24'hAAAAAA, 24'h555555, 24'hFFFE00, 24'h00FFFE}, 1'b0, '0},
      '{ROW_LATE_TAIL, 8'h44, 16'h0200, 16'h1111, 16'h2222, 16'h3333, {4{24'h040506}},
        1'b0, '0},
      '{ROW_RESTART, 8'h55, 16'hF000, 16'h0F0F, 16'hF0F0, 16'h00F0,
        {24'h111111, 24'h222222, 24'h333333, 24'h444444}, 1'b0, '0},
      '{ROW_NESTED, 8'h66, 16'h0080, 16'h8080, 16'h0101, 16'hFEFE,
        {24'h999999, 24'h888888, 24'h777777, 24'h666666}, 1'b0, '0},
      '{ROW_NOISE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, {4{24'h000000}}, 1'b0,
        '0},
      '{ROW_FRAME, 8'h00, 16'hC350, 16'hFFFF, 16'h8001, 16'h0003,
        {24'h000010, 24'h001000, 24'h100000, 24'hFFFFF0}, 1'b0, '0}
   };

   sensor_frame_deframer uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_stream_byte      (req_stream_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_equipment        (rsp_equipment),
      .rsp_temperature_q7   (rsp_temperature_q7),
      .rsp_supply_volts_q24 (rsp_supply_volts_q24),
      .rsp_bias_a_volts_q24 (rsp_bias_a_volts_q24),
      .rsp_bias_b_volts_q24 (rsp_bias_b_volts_q24),
      .rsp_count_first      (rsp_count_first),
      .rsp_count_second     (rsp_count_second),
      .rsp_count_third      (rsp_count_third),
      .rsp_count_fourth     (rsp_count_fourth),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic bit pair_at(input int pos, input logic [7:0] second);
      return line_window[pos] == SYNC_BYTE && line_window[pos + 1] == second;
   endfunction

   function automatic logic [15:0] word_at(input int pos);
      return {line_window[pos], line_window[pos + 1]};
   endfunction

   function automatic logic [23:0] count_at(input int pos);
      return {line_window[pos], line_window[pos + 1], line_window[pos + 2]};
   endfunction

   function automatic bit absorb_byte(input logic [7:0] value, output result_type frame);
      int          k;
      bit          id_match;
      logic [15:0] temp_code;
      logic [31:0] supply_coef;
      logic [31:0] bias_a_coef;
      logic [31:0] bias_b_coef;
      frame = '0;
      for (k = 0; k < FRAME_BYTES - 1; k++) line_window[k] = line_window[k + 1];
      line_window[FRAME_BYTES - 1] = value;
      if (skip_left != 0) begin
         skip_left--;
         return 1'b0;
      end
      if (!pair_at(0, HEAD_BYTE) || !pair_at(FRAME_BYTES - 2, TAIL_BYTE)) return 1'b0;
      for (k = 2; k <= FRAME_BYTES - 4; k++) begin
         if (pair_at(k, TAIL_BYTE)) return 1'b0;
      end
      skip_left = 6'(FRAME_BYTES - 1);
      id_match = line_window[EQUIPMENT_POS] == csr_model.match_equipment;
      supply_coef = (id_match && csr_model.match_enable_mask[MASK_SUPPLY]) ?
                    csr_model.supply_coef : SUPPLY_COEF_DEF;
      bias_a_coef = (id_match && csr_model.match_enable_mask[MASK_BIAS_A]) ?
                    csr_model.channel_a_coef : CHANNEL_COEF_DEF;
      bias_b_coef = (id_match && csr_model.match_enable_mask[MASK_BIAS_B]) ?
                    csr_model.channel_b_coef : CHANNEL_COEF_DEF;
      temp_code = word_at(TEMP_POS);
      frame.equipment        = line_window[EQUIPMENT_POS];
      frame.temperature_q7   = (temp_code == TEMP_INVALID) ? 16'h0000 : temp_code;
      frame.supply_volts_q24 = 48'(word_at(SUPPLY_POS)) * 48'(supply_coef);
      frame.bias_a_volts_q24 = 48'(word_at(BIAS_A_POS)) * 48'(bias_a_coef);
      frame.bias_b_volts_q24 = 48'(word_at(BIAS_B_POS)) * 48'(bias_b_coef);
      frame.count_first      = count_at(COUNT_FIRST_POS);
      frame.count_second     = count_at(COUNT_SECOND_POS);
      frame.count_third      = count_at(COUNT_THIRD_POS);
      frame.count_fourth     = count_at(COUNT_FOURTH_POS);
      return 1'b1;
   endfunction

   function automatic logic [23:0] random_field(input int bits);
      logic [23:0] ones;
      ones = 24'((32'd1 << bits) - 1);
      case ($urandom_range(0, 9))
         0: return 24'h000000;
         1: return ones;
         default: return 24'($urandom) & ones;
      endcase
   endfunction

   function automatic frame_row_type random_row();
      frame_row_type row;
      int            pick;
      int            k;
      pick = $urandom_range(0, 99);
      row.kind = (pick < 70) ? ROW_FRAME : (pick < 78) ? ROW_EARLY_TAIL :
                 (pick < 84) ? ROW_LATE_TAIL : (pick < 90) ? ROW_RESTART :
                 (pick < 94) ? ROW_NESTED : ROW_NOISE;
      row.equipment   = $urandom_range(0, 1) ? csr_model.match_equipment : 8'($urandom);
      row.temperature = 16'(random_field(16));
      row.supply_word = 16'(random_field(16));
      row.bias_a_word = 16'(random_field(16));
      row.bias_b_word = 16'(random_field(16));
      for (k = 0; k < 4; k++) row.counts[k] = random_field(24);
      row.typed       = 1'b0;
      row.typed_frame = '0;
      return row;
   endfunction

   function automatic void check_field(input string name, input logic [47:0] want_value,
                                       input logic [47:0] got_value);
      if (got_value !== want_value) begin
         $error("%s: expected %0h, got %0h", name, want_value, got_value);
         mismatches++;
      end
   endfunction

   task automatic send_byte(input logic [7:0] value);
      result_type decoded;
      int         gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) :
                      $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_stream_byte <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      burst_left--;
      bytes_sent++;
      if (absorb_byte(value, decoded)) begin
         if (table_pending) begin
            decoded = table_frame;
            table_pending = 1'b0;
         end
         frames_due.push_back(decoded);
         frames_predicted++;
      end
   endtask

   task automatic send_row(input frame_row_type row, input bit random_fill);
      logic [7:0] body [FRAME_BYTES];
      int         count_pos [4] = '{COUNT_FIRST_POS, COUNT_SECOND_POS, COUNT_THIRD_POS,
                                    COUNT_FOURTH_POS};
      int         k;
      int         extra;
      if (row.kind == ROW_NOISE) begin
         extra = $urandom_range(1, 16);
         repeat (extra) send_byte(8'($urandom));
         return;
      end
      for (k = 0; k < FRAME_BYTES; k++) body[k] = random_fill ? 8'($urandom) : 8'h00;
      for (k = 0; k < 4; k++) begin
         {body[count_pos[k]], body[count_pos[k] + 1], body[count_pos[k] + 2]} = row.counts[k];
      end
      body[EQUIPMENT_POS] = row.equipment;
      {body[TEMP_POS], body[TEMP_POS + 1]}     = row.temperature;
      {body[SUPPLY_POS], body[SUPPLY_POS + 1]} = row.supply_word;
      {body[BIAS_A_POS], body[BIAS_A_POS + 1]} = row.bias_a_word;
      {body[BIAS_B_POS], body[BIAS_B_POS + 1]} = row.bias_b_word;
      for (k = 2; k <= FRAME_BYTES - 4; k++) begin
         if (body[k] == SYNC_BYTE && body[k + 1] == TAIL_BYTE) body[k + 1] = 8'h00;
      end
      body[0]               = SYNC_BYTE;
      body[1]               = HEAD_BYTE;
      body[FRAME_BYTES - 2] = SYNC_BYTE;
      body[FRAME_BYTES - 1] = TAIL_BYTE;
      case (row.kind)
         ROW_EARLY_TAIL: begin
            k = $urandom_range(2, FRAME_BYTES - 4);
            body[k]     = SYNC_BYTE;
            body[k + 1] = TAIL_BYTE;
         end
         ROW_NESTED: begin
            k = $urandom_range(27, FRAME_BYTES - 4);
            body[k]     = SYNC_BYTE;
            body[k + 1] = HEAD_BYTE;
         end
         ROW_RESTART: begin
            send_byte(SYNC_BYTE);
            send_byte(HEAD_BYTE);
         end
         default: ;
      endcase
      for (k = 0; k < FRAME_BYTES - 2; k++) send_byte(body[k]);
      if (row.kind == ROW_LATE_TAIL) begin
         extra = $urandom_range(1, 3);
         repeat (extra) send_byte(8'($urandom_range(0, 8'hFC)));
      end
      send_byte(body[FRAME_BYTES - 2]);
      send_byte(body[FRAME_BYTES - 1]);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= data;
      @(posedge clock);
      case (index)
         CSR_MATCH_EQUIPMENT: csr_model.match_equipment   = data[7:0];
         CSR_MATCH_MASK:      csr_model.match_enable_mask = data[2:0];
         CSR_SUPPLY_COEF:     csr_model.supply_coef       = data;
         CSR_CHANNEL_A_COEF:  csr_model.channel_a_coef    = data;
         CSR_CHANNEL_B_COEF:  csr_model.channel_b_coef    = data;
         default: ;
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (frames_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (frames_due.size() == 0) begin
            $error("frame transfer with none expected, equipment %0h", rsp_equipment);
            mismatches++;
         end else begin
            due_frame = frames_due.pop_front();
            check_field("equipment", due_frame.equipment, rsp_equipment);
            check_field("temperature_q7", due_frame.temperature_q7, rsp_temperature_q7);
            check_field("supply_volts_q24", due_frame.supply_volts_q24, rsp_supply_volts_q24);
            check_field("bias_a_volts_q24", due_frame.bias_a_volts_q24, rsp_bias_a_volts_q24);
            check_field("bias_b_volts_q24", due_frame.bias_b_volts_q24, rsp_bias_b_volts_q24);
            check_field("count_first", due_frame.count_first, rsp_count_first);
            check_field("count_second", due_frame.count_second, rsp_count_second);
            check_field("count_third", due_frame.count_third, rsp_count_third);
            check_field("count_fourth", due_frame.count_fourth, rsp_count_fourth);
         end
      end
   end

   initial begin : receiver
      int run_left;
      bit run_ready;
      rsp_ready = 1'b0;
      run_left  = 0;
      run_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_wanted = 1'b0;
            run_left = 0;
         end
         if (run_left == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  run_ready = 1'b0;
                  run_left  = $urandom_range(1, 5);
               end
               1, 2: begin
                  run_ready = 1'b1;
                  run_left  = $urandom_range(1, 12);
               end
               default: begin
                  run_ready = 1'b1;
                  run_left  = $urandom_range(40, 160);
               end
            endcase
         end
         rsp_ready <= run_ready;
         run_left--;
      end
   end

   initial begin
      #1ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int start_bytes;
      int start_frames;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_stream_byte  = 8'h00;
      csr_write_enable = 1'b0;
      csr_index        = CSR_MATCH_EQUIPMENT;
      csr_wdata        = '0;
      foreach (line_window[k]) line_window[k] = 8'h00;
      skip_left = '0;
      csr_model = '{8'h00, 3'b000, SUPPLY_COEF_DEF, CHANNEL_COEF_DEF, CHANNEL_COEF_DEF};
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         table_pending = directed_rows[r].typed;
         table_frame   = directed_rows[r].typed_frame;
         send_row(directed_rows[r], 1'b0);
      end
      table_pending = 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: begin
               write_csr(CSR_MATCH_EQUIPMENT, 32'hFFFF_FF5A);
               write_csr(CSR_MATCH_MASK, 32'hFFFF_FFFF);
               write_csr(CSR_SUPPLY_COEF, $urandom);
               write_csr(CSR_CHANNEL_A_COEF, $urandom);
               write_csr(CSR_CHANNEL_B_COEF, $urandom);
               write_csr(CSR_SPARE_LOW, $urandom);
            end
            1: begin
               write_csr(CSR_MATCH_EQUIPMENT, 32'h0000_00FF);
               write_csr(CSR_MATCH_MASK, 32'h0000_0007);
               write_csr(CSR_SUPPLY_COEF, 32'hFFFF_FFFF);
               write_csr(CSR_CHANNEL_A_COEF, 32'hFFFF_FFFF);
               write_csr(CSR_CHANNEL_B_COEF, 32'hFFFF_FFFF);
               write_csr(CSR_SPARE_HIGH, $urandom);
            end
            2: begin
               write_csr(CSR_MATCH_EQUIPMENT, 32'h0000_0000);
               write_csr(CSR_MATCH_MASK, 32'hFFFF_FFF8);
               write_csr(CSR_SUPPLY_COEF, 32'h0000_0000);
               write_csr(CSR_CHANNEL_A_COEF, 32'h0000_0000);
               write_csr(CSR_CHANNEL_B_COEF, 32'h0000_0000);
            end
            3: begin
               write_csr(CSR_MATCH_MASK, 32'h0000_0007);
            end
            default: begin
               write_csr(CSR_MATCH_EQUIPMENT, $urandom);
               write_csr(CSR_MATCH_MASK, $urandom);
               write_csr(CSR_SUPPLY_COEF, $urandom);
               write_csr(CSR_CHANNEL_A_COEF, $urandom);
               write_csr(CSR_CHANNEL_B_COEF, $urandom);
            end
         endcase
         @(negedge clock);
         csr_write_enable <= 1'b0;
         hold_wanted  = (phase == 1);
         start_bytes  = bytes_sent;
         start_frames = frames_predicted;
         while (bytes_sent - start_bytes < PHASE_BYTES ||
                frames_predicted - start_frames < PHASE_FRAMES) begin
            send_row(random_row(), 1'b1);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sfd_pkg.sv
rtl/sfd_cell.sv
rtl/sfd_eval.sv
rtl/sfd_scale.sv
rtl/sensor_frame_deframer.sv
rtl/sfd_checker.sv
tb/sensor_frame_deframer_test.sv
